/* sv/vector_distance_linf_l1_l2_assert.svh */
// Assertion macros for the vector distance block.
// Expect signals named clk and rst_n in the scope of each use.
`ifndef VECTOR_DISTANCE_LINF_L1_L2_ASSERT_SVH
`define VECTOR_DISTANCE_LINF_L1_L2_ASSERT_SVH
`ifndef SYNTHESIS
`define VD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VD_ASSERT(lbl, prop, msg)
`define VD_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/vdist_pkg.sv */
// Shared types and constants for the vector distance block.
// No dependencies.
`default_nettype none
package vdist_pkg;

  localparam int ACC_W       = 43;
  localparam int DIST_W      = 42;
  localparam int CNT_OUT_W   = 11;
  localparam int ROOT_W      = (ACC_W + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int OUT_W       = ((DIST_W + CNT_OUT_W + 7) / 8) * 8;
  localparam int MAX_LEN_DEF = 1024;
  localparam int ELEM_W_DEF  = 16;
  localparam int QDEPTH_DEF  = 4;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_LINF = 2'd0,
    MODE_L1   = 2'd1,
    MODE_L2   = 2'd2,
    MODE_L2SQ = 2'd3
  } mode_t;

  // finished accumulation handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0]     acc;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 ovf;
    mode_t                mode;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* sv/vector_distance_linf_l1_l2.sv */
// Top level of the streaming vector distance block.
// Depends on vdist_pkg, vdist_front, vdist_fifo, vdist_back and the assert header.
//
// Usage:
//   in_*  : one word per component pair; tdata = elem_a (low), elem_b; tlast
//           marks the final pair of the vectors. One pair per cycle unless stalled (see below).
//   out_* : one word per vector; tdata = distance (low 42 bits), elem_count;
//           tuser = saturated.
//   cfg_* : metric_mode, written while idle; 0 L-inf, 1 L1, 2 L2, 3 squared L2.
// From the last pair to out_tvalid a result passes the stage 1 register, the
// queue and, in L2 mode, the root unit, which resolves one digit per cycle.
// A new vector may stream while earlier results wait: finished sums sit in a
// 4-deep queue between the accumulator and the root unit, and the back end
// takes the next result only once the result word is accepted. While
// out_tready is low the result word holds; pairs keep flowing until the queue
// is full and a last pair waits, then in_tready drops. Synchronous reset clears
// the accumulator, count, queue and out_tvalid, and sets the mode to L2.
`default_nettype none
`include "vector_distance_linf_l1_l2_assert.svh"
module vector_distance_linf_l1_l2 #(
  parameter int MAX_LEN     = vdist_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH  = vdist_pkg::ELEM_W_DEF,
  parameter int QUEUE_DEPTH = vdist_pkg::QDEPTH_DEF,
  localparam int IN_W       = ((2 * ELEM_WIDTH + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [1:0]                    cfg_wr_data,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [IN_W-1:0]               in_tdata,   // elem_a, elem_b, zero pad
  input  wire                          in_tlast,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [vdist_pkg::OUT_W-1:0]  out_tdata,  // distance, elem_count, zero pad
  output logic                         out_tuser   // saturated
);

  localparam int PAD_W = vdist_pkg::OUT_W - vdist_pkg::DIST_W - vdist_pkg::CNT_OUT_W;

  logic                            q_push, q_pop;
  vdist_pkg::res_t                 q_wr, q_rd;
  vdist_pkg::q_stat_t              q_stat;
  logic [vdist_pkg::DIST_W-1:0]    out_dist;
  logic [vdist_pkg::CNT_OUT_W-1:0] cnt;

  vdist_front #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_a        (in_tdata[ELEM_WIDTH-1:0]),
    .in_b        (in_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
    .in_last     (in_tlast),
    .q_push      (q_push),
    .q_data      (q_wr),
    .q_stat      (q_stat)
  );

  vdist_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  vdist_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_distance (out_dist),
    .out_count    (cnt),
    .out_sat      (out_tuser)
  );

  assign out_tdata = {{PAD_W{1'b0}}, cnt, out_dist};

  `VD_NEVER(a_push_full, q_push && q_stat.full, "result pushed into full queue")
  `VD_NEVER(a_pop_empty, q_pop && q_stat.empty, "result popped from empty queue")
  `VD_ASSERT(a_stall_cause, !in_tready |-> q_stat.full, "input stalled without full queue")

endmodule
`default_nettype wire

/* sv/vdist_front.sv */
// Front end: takes component pairs, forms |a-b| and its square, folds the
// running accumulator. Depends on vdist_pkg.
`default_nettype none
module vdist_front #(
  parameter int MAX_LEN    = vdist_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH = vdist_pkg::ELEM_W_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [1:0]                    cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [ELEM_WIDTH-1:0]         in_a,
  input  wire [ELEM_WIDTH-1:0]         in_b,
  input  wire                          in_last,
  output logic                         q_push,
  output vdist_pkg::res_t              q_data,
  input  wire vdist_pkg::q_stat_t      q_stat
);

  localparam int AD_W  = ELEM_WIDTH + 1;
  localparam int SQ_W  = 2 * AD_W;
  localparam int SQX_W = (SQ_W > vdist_pkg::ACC_W) ? SQ_W : vdist_pkg::ACC_W;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int AW    = vdist_pkg::ACC_W;

  vdist_pkg::mode_t mode_r;

  // stage 1 registers
  logic             st1_v_r;
  logic             st1_last_r;
  vdist_pkg::mode_t st1_mode_r;
  logic [AD_W-1:0]  st1_ad_r;
  logic [SQ_W-1:0]  st1_sq_r;

  // accumulation state
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic [AD_W-1:0]  d_u, ad;
  logic [SQ_W-1:0]  sq;
  logic             st1_adv;
  logic             in_acc;
  logic [SQX_W-1:0] sq_ext;
  logic [AW-1:0]    sq_sat, ad_ext;

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, vdist_pkg::ACC_MAX}) ? vdist_pkg::ACC_MAX : s[AW-1:0];
  endfunction

  assign d_u = {in_a[ELEM_WIDTH-1], in_a} - {in_b[ELEM_WIDTH-1], in_b};
  assign ad  = d_u[AD_W-1] ? (~d_u + 1'b1) : d_u;
  assign sq  = ad * ad;

  assign st1_adv  = st1_v_r && !(st1_last_r && q_stat.full);
  assign in_ready = !st1_v_r || st1_adv;
  assign in_acc   = in_valid && in_ready;

  assign sq_ext = SQX_W'(st1_sq_r);
  assign sq_sat = (sq_ext >= SQX_W'(vdist_pkg::ACC_MAX)) ? vdist_pkg::ACC_MAX
                                                         : AW'(sq_ext);
  assign ad_ext = AW'(st1_ad_r);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cnt_r >= CW'(MAX_LEN)) begin
      // vector too long: pin accumulator at full scale
      ovf_nxt = 1'b1;
      acc_nxt = vdist_pkg::ACC_MAX;
      cnt_nxt = CW'(MAX_LEN);
    end else begin
      cnt_nxt = cnt_r + 1'b1;
      if (!ovf_r) begin
        case (st1_mode_r)
          vdist_pkg::MODE_LINF: if (ad_ext > acc_r) acc_nxt = ad_ext;
          vdist_pkg::MODE_L1:   acc_nxt = sat_add(acc_r, ad_ext);
          default:              acc_nxt = sat_add(acc_r, sq_sat);
        endcase
      end
    end
  end

  assign q_push      = st1_adv && st1_last_r;
  assign q_data.acc  = acc_nxt;
  assign q_data.cnt  = vdist_pkg::CNT_OUT_W'(cnt_nxt);
  assign q_data.ovf  = ovf_nxt;
  assign q_data.mode = st1_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= vdist_pkg::MODE_L2;
      st1_v_r <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= vdist_pkg::mode_t'(cfg_wr_data);
      if (in_acc) st1_v_r <= 1'b1;
      else if (st1_adv) st1_v_r <= 1'b0;
      if (st1_adv) begin
        if (st1_last_r) begin
          acc_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st1_last_r <= in_last;
      st1_mode_r <= mode_r;
      st1_ad_r   <= ad;
      st1_sq_r   <= sq;
    end
  end

endmodule
`default_nettype wire

/* sv/vdist_fifo.sv */
// Small result queue between front and back ends.
// Depends on vdist_pkg.
`default_nettype none
module vdist_fifo #(
  parameter int DEPTH = vdist_pkg::QDEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire vdist_pkg::res_t wr_data,
  input  wire                 pop,
  output vdist_pkg::res_t     rd_data,
  output vdist_pkg::q_stat_t  stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vdist_pkg::res_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/vdist_back.sv */
// Back end: drains the queue, takes the square root for L2 one digit per
// cycle, clamps and holds the result word. Depends on vdist_pkg.
`default_nettype none
module vdist_back (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire vdist_pkg::q_stat_t             q_stat,
  input  wire vdist_pkg::res_t                q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [vdist_pkg::DIST_W-1:0]        out_distance,
  output logic [vdist_pkg::CNT_OUT_W-1:0]     out_count,
  output logic                                out_sat
);

  localparam int RW    = vdist_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int STW   = $clog2(RW);

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_OUT} st_t;

  st_t                            st_r;
  logic [vdist_pkg::DIST_W-1:0]   dist_r;
  logic [vdist_pkg::CNT_OUT_W-1:0] cnt_r;
  logic                           sat_r;
  logic [vdist_pkg::RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]               rem_r;
  logic [RW-1:0]                  root_r;
  logic [STW-1:0]                 step_r;

  logic [SH_W-1:0] rem_sh, trial;
  logic            ge;
  logic [RW-1:0]   root_nxt;

  // restoring root digit: bring down two radicand bits, try root*4+1
  assign rem_sh   = {rem_r, rad_r[vdist_pkg::RAD_W-1 -: 2]};
  assign trial    = SH_W'({root_r, 2'b01});
  assign ge       = (rem_sh >= trial);
  assign root_nxt = {root_r[RW-2:0], ge};

  assign q_pop        = (st_r == S_IDLE) && !q_stat.empty;
  assign out_valid    = (st_r == S_OUT);
  assign out_distance = dist_r;
  assign out_count    = cnt_r;
  assign out_sat      = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cnt_r <= q_data.cnt;
            sat_r <= q_data.ovf;
            if (q_data.ovf) begin
              dist_r <= vdist_pkg::DIST_MAX;
              st_r   <= S_OUT;
            end else if (q_data.mode == vdist_pkg::MODE_L2) begin
              rad_r  <= vdist_pkg::RAD_W'(q_data.acc);
              rem_r  <= '0;
              root_r <= '0;
              step_r <= '0;
              st_r   <= S_ROOT;
            end else begin
              dist_r <= q_data.acc[vdist_pkg::ACC_W-1] ? vdist_pkg::DIST_MAX
                                                       : q_data.acc[vdist_pkg::DIST_W-1:0];
              st_r   <= S_OUT;
            end
          end
        end
        S_ROOT: begin
          rem_r  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
          root_r <= root_nxt;
          rad_r  <= rad_r << 2;
          step_r <= step_r + 1'b1;
          if (step_r == STW'(RW - 1)) begin
            dist_r <= vdist_pkg::DIST_W'(root_nxt);
            st_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
